// ===== src/ias_pkg.sv =====
// Package for the integer array sorter: data width, default capacity and sequencer state codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ias_pkg;

   localparam int DATA_W           = 32;
   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INS  = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

endpackage

// ===== src/integer_array_sorter_unit.sv =====
// Top level of the integer array sorter: sequencer, entry store, compare unit.
// Depends on ias_pkg, ias_cmp, ias_store, ias_seq.
`timescale 1ns / 1ps
//
// Usage:
//  - Input: a transfer happens on a rising edge with start high and busy low.
//    req_value is a signed 32-bit integer; req_last_in marks the final item
//    of a set. Up to CAPACITY items are held; later ones of the same set are
//    dropped and every result of that set then carries rsp_overflow.
//  - Each stored item is placed in order on arrival: the entries above it
//    move up one place per compare, each compare a registered memory read,
//    then compare and write. After the transfer busy stays high while the
//    item is placed: one compare for each held entry greater than the item,
//    and one more unless it lands at the bottom. A dropped item that is not
//    last leaves busy low.
//  - After the last item of a set, the n entries stream out smallest first,
//    one per cycle on rsp_strobe; rsp_last_out marks the largest. busy drops
//    as the last result shows, so the next set may start in that cycle.
//  - Results are shown for one cycle only; the receiver cannot stall them.
//  - Synchronous reset empties the set and clears the overflow flag; the
//    store contents are not cleared, none is read before it is written.
//
module integer_array_sorter_unit
   import ias_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last_in,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_out,
   output logic                     rsp_overflow
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [DATA_W-1:0] cmp_a;
   logic [DATA_W-1:0] cmp_b;
   logic              cmp_lt;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [DATA_W-1:0] mem_rdata;

   // control: insertion shifts and ordered readout
   ias_seq #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .req_last_in  (req_last_in),
      .cmp_a        (cmp_a),
      .cmp_b        (cmp_b),
      .cmp_lt       (cmp_lt),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .rsp_strobe   (rsp_strobe),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

   // the one comparator, used once per shift step
   ias_cmp u_cmp (
      .cmp_a  (cmp_a),
      .cmp_b  (cmp_b),
      .cmp_lt (cmp_lt)
   );

   // entries kept sorted; read data doubles as the result register
   ias_store #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W)
   ) u_store (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   assign rsp_sorted_value = mem_rdata;

endmodule

// ===== src/ias_cmp.sv =====
// Shared signed compare unit of the sorter.
// Depends on ias_pkg.
`timescale 1ns / 1ps

module ias_cmp
   import ias_pkg::*;
(
   input  logic [DATA_W-1:0] cmp_a,
   input  logic [DATA_W-1:0] cmp_b,
   output logic              cmp_lt
);

   // two's complement less-than
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

endmodule

// ===== src/ias_store.sv =====
// Entry store of the sorter: one write port, one read port, registered read data.
// Depends on ias_pkg.
`timescale 1ns / 1ps

module ias_store
   import ias_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int ADDR_W   = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  logic              mem_we,
   input  logic [ADDR_W-1:0] mem_waddr,
   input  logic [DATA_W-1:0] mem_wdata,
   input  logic [ADDR_W-1:0] mem_raddr,
   output logic [DATA_W-1:0] mem_rdata
);

   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[mem_raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== src/ias_seq.sv =====
// Sequencer of the sorter: insertion of each item by shifting, then ordered readout.
// Depends on ias_pkg; drives ias_store and ias_cmp.
`timescale 1ns / 1ps

module ias_seq
   import ias_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int ADDR_W   = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [DATA_W-1:0] req_value,
   input  logic              req_last_in,
   output logic [DATA_W-1:0] cmp_a,
   output logic [DATA_W-1:0] cmp_b,
   input  logic              cmp_lt,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [DATA_W-1:0] mem_wdata,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [DATA_W-1:0] mem_rdata,
   output logic              rsp_strobe,
   output logic              rsp_last_out,
   output logic              rsp_overflow
);

   logic [1:0]        state_ff,   state_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic              dropped_ff, dropped_in;
   logic              last_ff,    last_in;
   logic [DATA_W-1:0] key_ff,     key_in;
   logic [CNT_W-1:0]  pos_ff,     pos_in;
   logic [CNT_W-1:0]  emit_ff,    emit_in;
   logic              strobe_ff,  strobe_in;
   logic              lastp_ff,   lastp_in;
   logic              ovf_ff,     ovf_in;

   logic [CNT_W-1:0]  pos_m1;
   logic [CNT_W-1:0]  count_m1;
   logic              full;

   assign pos_m1   = pos_ff - 1'b1;
   assign count_m1 = count_ff - 1'b1;
   assign full     = (count_ff == CNT_W'(CAPACITY));

   assign cmp_a = key_ff;
   assign cmp_b = mem_rdata;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      last_in    = last_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      emit_in    = emit_ff;
      strobe_in  = 1'b0;
      lastp_in   = 1'b0;
      ovf_in     = dropped_ff;
      mem_we     = 1'b0;
      mem_waddr  = pos_ff[ADDR_W-1:0];
      mem_wdata  = key_ff;
      mem_raddr  = pos_m1[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!full) begin
                  key_in   = req_value;
                  pos_in   = count_ff;
                  count_in = count_ff + 1'b1;
                  last_in  = req_last_in;
                  state_in = ST_INS;
               end else begin
                  dropped_in = 1'b1;
                  if (req_last_in) begin
                     emit_in  = '0;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_INS: begin
            if (pos_ff == '0) begin
               mem_we = 1'b1;
               if (last_ff) begin
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               // fetch the neighbor below the hole
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            mem_we = 1'b1;
            if (cmp_lt) begin
               // neighbor moves up one place, hole moves down
               mem_wdata = mem_rdata;
               pos_in    = pos_m1;
               state_in  = ST_INS;
            end else if (last_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            mem_raddr = emit_ff[ADDR_W-1:0];
            strobe_in = 1'b1;
            lastp_in  = (emit_ff == count_m1);
            emit_in   = emit_ff + 1'b1;
            if (emit_ff == count_m1) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         last_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
         lastp_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
         pos_ff     <= '0;
         emit_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         last_ff    <= last_in;
         strobe_ff  <= strobe_in;
         lastp_ff   <= lastp_in;
         ovf_ff     <= ovf_in;
         pos_ff     <= pos_in;
         emit_ff    <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_last_out = lastp_ff;
   assign rsp_overflow = ovf_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == ST_EMIT)
      else $error("result strobe without readout");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> count_ff != '0)
      else $error("readout of an empty set");

   a_cmp_hole: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> pos_ff != '0)
      else $error("compare with no neighbor below");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      lastp_ff |-> count_ff == '0 && !dropped_ff && state_ff == ST_IDLE)
      else $error("set not cleared after final result");
`endif

endmodule
